// File: src/eot_pkg.sv
`default_nettype none

package eot_pkg;

  // Table geometry
  localparam int unsigned FloorCount  = 4;
  localparam int unsigned FloorW      = 2;
  localparam int unsigned DistW       = 3;
  localparam int unsigned ButtonTypes = 3;

  // Distance code meaning "no order in that direction"
  localparam logic [DistW-1:0] DistNone = DistW'(FloorCount);

  // Button type codes carried in clear_button
  typedef enum logic [1:0] {
    BTN_UP   = 2'd0,
    BTN_DOWN = 2'd1,
    BTN_CAB  = 2'd2
  } btn_e;

  // Input beat
  typedef struct packed {
    logic [FloorCount-1:0] up_pressed;
    logic [FloorCount-1:0] down_pressed;
    logic [FloorCount-1:0] cab_pressed;
    logic                  clear_valid;
    logic [1:0]            clear_button;
    logic [FloorW-1:0]     clear_floor;
    logic                  clear_everything;
    logic [FloorW-1:0]     car_floor;
  } eot_in_t;

  // Output beat
  typedef struct packed {
    logic [FloorCount-1:0] up_lamps;
    logic [FloorCount-1:0] down_lamps;
    logic [FloorCount-1:0] cab_lamps;
    logic [DistW-1:0]      cab_dist_up;
    logic [DistW-1:0]      cab_dist_down;
    logic [DistW-1:0]      hall_dist_up;
    logic [DistW-1:0]      hall_dist_down;
    logic                  order_above;
    logic                  order_below;
  } eot_out_t;

  // The three order masks
  typedef struct packed {
    logic [FloorCount-1:0] up;
    logic [FloorCount-1:0] down;
    logic [FloorCount-1:0] cab;
  } eot_orders_t;

  // Distance queries for one floor
  typedef struct packed {
    logic [DistW-1:0] cab_up;
    logic [DistW-1:0] cab_down;
    logic [DistW-1:0] hall_up;
    logic [DistW-1:0] hall_down;
  } eot_dist_t;

endpackage

`default_nettype wire

// File: src/eot_table.sv
`default_nettype none

module eot_table
  import eot_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        upd_en_i,
  input  wire eot_in_t     item_i,
  output eot_orders_t      orders_d_o
);

  localparam logic [FloorCount-1:0] AllFloors  = '1;
  localparam logic [FloorCount-1:0] UpExists   = AllFloors >> 1;
  localparam logic [FloorCount-1:0] DownExists = AllFloors << 1;

  eot_orders_t orders_q, orders_d;
  eot_orders_t cleared;
  logic [FloorCount-1:0] clr_bit;
  logic clr_ok;

  // clear-all, then single clear, then presses
  always_comb begin
    cleared = item_i.clear_everything ? '0 : orders_q;
    clr_ok  = item_i.clear_valid && (32'(item_i.clear_floor) < FloorCount);
    clr_bit = FloorCount'(1) << item_i.clear_floor;
    if (clr_ok) begin
      case (item_i.clear_button)
        BTN_UP:   cleared.up   = cleared.up   & ~clr_bit;
        BTN_DOWN: cleared.down = cleared.down & ~clr_bit;
        BTN_CAB:  cleared.cab  = cleared.cab  & ~clr_bit;
        default:  ;
      endcase
    end
    orders_d.up   = cleared.up   | (item_i.up_pressed   & UpExists);
    orders_d.down = cleared.down | (item_i.down_pressed & DownExists);
    orders_d.cab  = cleared.cab  | (item_i.cab_pressed  & AllFloors);
  end

  // table state moves with each beat handed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orders_q <= '0;
    end else if (upd_en_i) begin
      orders_q <= orders_d;
    end
  end

  assign orders_d_o = orders_d;

endmodule

`default_nettype wire

// File: src/eot_query.sv
`default_nettype none

module eot_query
  import eot_pkg::*;
(
  input  wire eot_orders_t  orders_i,
  input  wire logic [FloorW-1:0] cur_i,
  output eot_dist_t         dist_o
);

  logic [FloorCount-1:0] hall;
  logic [FloorW:0] idx_up, idx_dn;

  // nearest set bit above and below; scan far to near so the nearest wins
  always_comb begin
    hall   = orders_i.up | orders_i.down;
    dist_o = '{cab_up: DistNone, cab_down: DistNone,
               hall_up: DistNone, hall_down: DistNone};
    idx_up = '0;
    idx_dn = '0;
    for (int d = FloorCount - 1; d >= 1; d--) begin
      idx_up = {1'b0, cur_i} + (FloorW+1)'(d);
      idx_dn = {1'b0, cur_i} - (FloorW+1)'(d);
      if (32'(idx_up) < FloorCount) begin
        if (orders_i.cab[idx_up[FloorW-1:0]]) dist_o.cab_up  = DistW'(d);
        if (hall[idx_up[FloorW-1:0]])         dist_o.hall_up = DistW'(d);
      end
      if (32'(cur_i) >= 32'(d)) begin
        if (orders_i.cab[idx_dn[FloorW-1:0]]) dist_o.cab_down  = DistW'(d);
        if (hall[idx_dn[FloorW-1:0]])         dist_o.hall_down = DistW'(d);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/elevator_order_table_unit.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (eot_in_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (eot_out_t)
//
// Two register stages: an input register, then the result register, which raises
// out_valid_o; one beat per cycle is sustained while out_ready_i is high. The order
// table updates as a beat moves into the result register. Reset clears the order
// table and both valid flags. A stalled out beat holds the result; one further in
// beat is still taken into the input register.
`default_nettype none

module elevator_order_table_unit
  import eot_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire eot_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output eot_out_t      out_data_o
);

  logic        in_valid_q;
  eot_in_t     in_data_q;
  logic        out_valid_q;
  eot_out_t    out_data_q, out_data_d;
  logic        advance;
  eot_orders_t orders_d;
  eot_dist_t   dists;

  // stage handshake
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  eot_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_en_i   (advance),
    .item_i     (in_data_q),
    .orders_d_o (orders_d)
  );

  eot_query u_query (
    .orders_i (orders_d),
    .cur_i    (in_data_q.car_floor),
    .dist_o   (dists)
  );

  // result assembly
  always_comb begin
    out_data_d.up_lamps       = orders_d.up;
    out_data_d.down_lamps     = orders_d.down;
    out_data_d.cab_lamps      = orders_d.cab;
    out_data_d.cab_dist_up    = dists.cab_up;
    out_data_d.cab_dist_down  = dists.cab_down;
    out_data_d.hall_dist_up   = dists.hall_up;
    out_data_d.hall_dist_down = dists.hall_down;
    out_data_d.order_above    = (dists.cab_up != DistNone) || (dists.hall_up != DistNone);
    out_data_d.order_below    = (dists.cab_down != DistNone) || (dists.hall_down != DistNone);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: src/eot_checker.sv
`default_nettype none

module eot_checker
  import eot_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire eot_out_t out_data_o
);

  // a stalled out beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("out beat dropped or changed while stalled");

  // input back-pressure only while a result waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // hall-up at the top floor and hall-down at floor 0 never light
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.up_lamps[FloorCount-1] && !out_data_o.down_lamps[0])
    else $error("nonexistent hall lamp lit");

  // above/below flags agree with the distance fields
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.order_above ==
        ((out_data_o.cab_dist_up != DistNone) || (out_data_o.hall_dist_up != DistNone))) &&
      (out_data_o.order_below ==
        ((out_data_o.cab_dist_down != DistNone) || (out_data_o.hall_dist_down != DistNone))))
    else $error("order flags disagree with distances");

  // after an in beat is taken, in_ready_o is not unknown
  a_in_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$isunknown(in_ready_o))
    else $error("input ready unknown after a taken beat");

endmodule

bind elevator_order_table_unit eot_checker u_eot_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import eot_pkg::*;

  // Clear code outside the button types; the single clear must do nothing
  localparam logic [1:0] BtnUnknown = 2'd3;

  // Buttons that physically exist: no hall up at the top, no hall down at floor 0
  localparam logic [FloorCount-1:0] UpExists   = {1'b0, {(FloorCount-1){1'b1}}};
  localparam logic [FloorCount-1:0] DownExists = {{(FloorCount-1){1'b1}}, 1'b0};

  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned HoldOffLen   = 400;
  localparam int unsigned RandomBeats  = 290;
  localparam int unsigned DrainCycles  = 8;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  eot_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  eot_out_t out_data;

  // Predicted order table
  logic [FloorCount-1:0] ord_up;
  logic [FloorCount-1:0] ord_down;
  logic [FloorCount-1:0] ord_cab;

  eot_out_t    status_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned error_count;

  elevator_order_table_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Distance to nearest set floor above cur, DistNone if none
  function automatic logic [DistW-1:0] floors_above(logic [FloorCount-1:0] mask, int cur);
    for (int f = cur + 1; f < int'(FloorCount); f++) begin
      if (mask[f]) return DistW'(f - cur);
    end
    return DistNone;
  endfunction

  // Distance to nearest set floor below cur, DistNone if none
  function automatic logic [DistW-1:0] floors_below(logic [FloorCount-1:0] mask, int cur);
    for (int f = cur - 1; f >= 0; f--) begin
      if (mask[f]) return DistW'(cur - f);
    end
    return DistNone;
  endfunction

  // Apply clear-all, single clear, then presses; return lamps and queries
  function automatic eot_out_t next_status(eot_in_t b);
    eot_out_t              r;
    logic [FloorCount-1:0] hall;
    logic [FloorCount-1:0] sel;
    int                    cur;
    if (b.clear_everything) begin
      ord_up   = '0;
      ord_down = '0;
      ord_cab  = '0;
    end
    if (b.clear_valid && b.clear_floor < FloorCount) begin
      sel = FloorCount'(1) << b.clear_floor;
      case (b.clear_button)
        BTN_UP:   ord_up   &= ~sel;
        BTN_DOWN: ord_down &= ~sel;
        BTN_CAB:  ord_cab  &= ~sel;
        default: ;
      endcase
    end
    ord_up   |= b.up_pressed & UpExists;
    ord_down |= b.down_pressed & DownExists;
    ord_cab  |= b.cab_pressed;
    hall = ord_up | ord_down;
    cur  = int'(b.car_floor);
    r.up_lamps       = ord_up;
    r.down_lamps     = ord_down;
    r.cab_lamps      = ord_cab;
    r.cab_dist_up    = floors_above(ord_cab, cur);
    r.cab_dist_down  = floors_below(ord_cab, cur);
    r.hall_dist_up   = floors_above(hall, cur);
    r.hall_dist_down = floors_below(hall, cur);
    r.order_above    = (r.cab_dist_up != DistNone) || (r.hall_dist_up != DistNone);
    r.order_below    = (r.cab_dist_down != DistNone) || (r.hall_dist_down != DistNone);
    return r;
  endfunction

  function automatic eot_in_t make_beat(logic [3:0] up, logic [3:0] down, logic [3:0] cab,
                                        logic clr, logic [1:0] btn, logic [1:0] flr,
                                        logic clr_all, logic [1:0] cur);
    eot_in_t b;
    b.up_pressed       = up;
    b.down_pressed     = down;
    b.cab_pressed      = cab;
    b.clear_valid      = clr;
    b.clear_button     = btn;
    b.clear_floor      = flr;
    b.clear_everything = clr_all;
    b.car_floor        = cur;
    return b;
  endfunction

  // Sparse presses so clears and distances stay interesting
  function automatic eot_in_t random_beat();
    eot_in_t b;
    b.up_pressed       = FloorCount'($urandom_range(0, 15) & $urandom_range(0, 15)
                                     & $urandom_range(0, 15));
    b.down_pressed     = FloorCount'($urandom_range(0, 15) & $urandom_range(0, 15)
                                     & $urandom_range(0, 15));
    b.cab_pressed      = FloorCount'($urandom_range(0, 15) & $urandom_range(0, 15)
                                     & $urandom_range(0, 15));
    b.clear_valid      = $urandom_range(0, 3) != 0;
    b.clear_button     = 2'($urandom_range(0, 3));
    b.clear_floor      = FloorW'($urandom_range(0, 3));
    b.clear_everything = $urandom_range(0, 15) == 0;
    b.car_floor        = FloorW'($urandom_range(0, 3));
    return b;
  endfunction

  // Offer one beat with random lead-in gaps, predict it once accepted
  task automatic send_beat(eot_in_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    status_q.push_back(next_status(b));
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // Extremes, each button type, clears against presses, query floors
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b0, 2'd0));
    send_beat(make_beat(4'hF, 4'hF, 4'hF, 1'b0, BTN_UP, 2'd0, 1'b0, 2'd0));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b0, 2'd3));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b0, 2'd1));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b1, BTN_UP, 2'd0, 1'b0, 2'd2));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b1, BTN_DOWN, 2'd3, 1'b0, 2'd2));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b1, BTN_CAB, 2'd3, 1'b0, 2'd0));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b1, BTN_CAB, 2'd0, 1'b0, 2'd3));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b1, BtnUnknown, 2'd1, 1'b0, 2'd1));
    // clear and press of the same order in one step: order stays
    send_beat(make_beat(4'h0, 4'h0, 4'h2, 1'b1, BTN_CAB, 2'd1, 1'b0, 2'd1));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b1, BTN_UP, 2'd3, 1'b0, 2'd0));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b1, 2'd2));
    // clear-all with presses in the same step
    send_beat(make_beat(4'h1, 4'h0, 4'h8, 1'b1, BTN_CAB, 2'd3, 1'b1, 2'd0));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b0, 2'd3));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b1, 2'd0));
    send_beat(make_beat(4'h0, 4'h0, 4'h4, 1'b0, BTN_UP, 2'd0, 1'b0, 2'd0));
    send_beat(make_beat(4'h0, 4'h2, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b0, 2'd3));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b0, 2'd2));
    // nonexistent buttons only: table stays empty
    send_beat(make_beat(4'h8, 4'h1, 4'h0, 1'b0, BTN_UP, 2'd0, 1'b1, 2'd1));
    send_beat(make_beat(4'h0, 4'h0, 4'h0, 1'b1, BTN_DOWN, 2'd1, 1'b0, 2'd1));
    drain();
  endtask

  task automatic test_random(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (RandomBeats) send_beat(random_beat());
    drain();
  endtask

  // Output held off for a long stretch while beats keep coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = HoldOffLen;
    repeat (40) send_beat(random_beat());
    drain();
  endtask

  // Output side: random stalls, or a counted hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, expected none actual %h", $time, out_data);
      end else begin
        eot_out_t want;
        want = status_q.pop_front();
        check_field("up_lamps", 32'(want.up_lamps), 32'(out_data.up_lamps));
        check_field("down_lamps", 32'(want.down_lamps), 32'(out_data.down_lamps));
        check_field("cab_lamps", 32'(want.cab_lamps), 32'(out_data.cab_lamps));
        check_field("cab_dist_up", 32'(want.cab_dist_up), 32'(out_data.cab_dist_up));
        check_field("cab_dist_down", 32'(want.cab_dist_down), 32'(out_data.cab_dist_down));
        check_field("hall_dist_up", 32'(want.hall_dist_up), 32'(out_data.hall_dist_up));
        check_field("hall_dist_down", 32'(want.hall_dist_down),
                    32'(out_data.hall_dist_down));
        check_field("order_above", 32'(want.order_above), 32'(out_data.order_above));
        check_field("order_below", 32'(want.order_below), 32'(out_data.order_below));
        beats_checked++;
      end
    end
  end

  // Watchdog: cycles without any beat on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat moved for %0d cycles", StallLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    ord_up         = '0;
    ord_down       = '0;
    ord_cab        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    beats_sent     = 0;
    beats_checked  = 0;
    error_count    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(0, 0);
    test_random(73, 0);
    test_random(0, 73);
    test_random(8, 8);
    test_backpressure();

    if (status_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d predicted results never arrived", $time, status_q.size());
    end
    $display("Ran %0d order beats (directed, four idle/stall mixes, long output hold-off);",
             beats_sent);
    $display("%0d result beats compared field by field, %0d errors.", beats_checked,
             error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
